>>> sv/vchp_pkg.sv
`default_nettype none
package vchp_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_VEHICLE_WIDTH = 3'd0;
  localparam logic [2:0] REG_FRONT_OFFSET  = 3'd1;
  localparam logic [2:0] REG_REAR_OFFSET   = 3'd2;
  localparam logic [2:0] REG_SLACK_LIMIT   = 3'd3;
  localparam logic [2:0] REG_SIDE_MARGIN   = 3'd4;
  localparam logic [2:0] REG_FACE_MARGIN   = 3'd5;

  // turn scale split into a 14-bit upper part and a 32-bit lower half
  localparam logic [31:0] TURN_LO = 32'd1625002897;
  localparam logic [13:0] TURN_HI = 14'd10430;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;

  // reciprocal constants for exact floor division of 31-bit values
  localparam logic [5:0] SH_42 = 6'd37;
  localparam logic [5:0] SH_56 = 6'd37;
  localparam logic [5:0] SH_20 = 6'd36;
  localparam logic [5:0] SH_30 = 6'd36;
  localparam logic [5:0] SH_6  = 6'd34;
  localparam logic [5:0] SH_12 = 6'd35;
  localparam logic [32:0] RCP_42 = 33'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [32:0] RCP_56 = 33'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [32:0] RCP_20 = 33'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [32:0] RCP_30 = 33'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [32:0] RCP_6  = 33'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam logic [32:0] RCP_12 = 33'(((64'd1 << 35) + 64'd11) / 64'd12);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] left_clear;
    logic signed [31:0] right_clear;
    logic signed [31:0] front_clear;
    logic signed [31:0] back_clear;
    logic               last_point;
  } point_t;

  function automatic logic [30:0] div_rcp(input logic [30:0] x, input logic [32:0] m,
                                          input logic [5:0] sh);
    logic [63:0] p;
    p = {33'd0, x} * {31'd0, m};
    div_rcp = 31'(p >> sh);
  endfunction

  function automatic logic [30:0] mul30u(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = {31'd0, a} * {31'd0, b};
    mul30u = p[60:30];
  endfunction

  function automatic logic signed [17:0] to_q16(input logic signed [32:0] v);
    logic signed [33:0] r;
    r = (34'(v) + 34'sd8192) >>> 14;
    if (r > 34'sd65536) to_q16 = 18'sd65536;
    else if (r < -34'sd65536) to_q16 = -18'sd65536;
    else to_q16 = r[17:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -50'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/vehicle_collision_halfplane_coeffs.sv
`default_nettype none
// Collision half-plane rows for a path planner. Each request on the in_ channel is one path
// point; the block answers with eight rows on the out_ channel, row_kind 0 to 7 in order (left
// side at front and rear offset, right side likewise, front face and rear face each at minus
// and plus half width), the eighth flagged last_of_point and, for the final point, last_of_path.
// A point passes 14 pipeline stages (11 for the phase and sine/cosine series, 3 for the row
// terms) and is then loaded into the row serialiser, which offers one row per cycle while
// out_stall is low. The pipeline keeps accepting points while rows of an earlier point are
// still going out, and only stalls its input when a finished point waits for the row
// serialiser. Write the configuration registers only while no point is in flight.
module vehicle_collision_halfplane_coeffs
  import vchp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_heading,
  input  wire logic signed [31:0] in_left_clear,
  input  wire logic signed [31:0] in_right_clear,
  input  wire logic signed [31:0] in_front_clear,
  input  wire logic signed [31:0] in_back_clear,
  input  wire logic               in_last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_row_kind,
  output logic signed [17:0]      out_normal_x,
  output logic signed [17:0]      out_normal_y,
  output logic signed [31:0]      out_heading_coeff,
  output logic signed [31:0]      out_constant_term,
  output logic                    out_slack_column,
  output logic                    out_last_of_point,
  output logic                    out_last_of_path
);

  localparam int SC_LAT = 11;

  // configuration registers
  logic [30:0] width_r, lf_r, lr_r, slack_r, side_r, face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 31'd131072;
      lf_r    <= 31'd196608;
      lr_r    <= 31'd65536;
      slack_r <= 31'd0;
      side_r  <= 31'd0;
      face_r  <= 31'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VEHICLE_WIDTH: width_r <= cfg_data;
        REG_FRONT_OFFSET:  lf_r    <= cfg_data;
        REG_REAR_OFFSET:   lr_r    <= cfg_data;
        REG_SLACK_LIMIT:   slack_r <= cfg_data;
        REG_SIDE_MARGIN:   side_r  <= cfg_data;
        REG_FACE_MARGIN:   face_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: everything moves unless the last stage holds a point the serialiser
  // cannot take yet
  logic en;
  logic load;
  logic v14_r;
  logic ser_v_r;
  logic [2:0] k_r;
  logic out_acc;

  assign out_acc  = ser_v_r & ~out_stall;
  assign load     = v14_r & (~ser_v_r | (out_acc & (k_r == 3'd7)));
  assign en       = ~v14_r | load;
  assign in_stall = ~en;

  point_t in_pt;
  assign in_pt = '{pos_x: in_pos_x, pos_y: in_pos_y, heading: in_heading,
                   left_clear: in_left_clear, right_clear: in_right_clear,
                   front_clear: in_front_clear, back_clear: in_back_clear,
                   last_point: in_last_point};

  // payload delay line alongside the sine/cosine pipeline
  point_t            dl_r [SC_LAT];
  logic [SC_LAT-1:0] dv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= in_pt;
      for (int i = 1; i < SC_LAT; i++) dl_r[i] <= dl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r <= '0;
    else if (en) dv_r <= {dv_r[SC_LAT-2:0], in_valid};
  end

  logic signed [17:0] sin_q16, cos_q16;

  vchp_sincos u_sincos (
    .clk     (clk),
    .en      (en),
    .heading (in_heading),
    .sin_q16 (sin_q16),
    .cos_q16 (cos_q16)
  );

  point_t pt;
  assign pt = dl_r[SC_LAT-1];

  // stage 12: products
  logic v12_r;
  logic signed [49:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [63:0] p_lf_r, p_lr_r, p_w_r;
  logic signed [17:0] s12_r, c12_r;
  logic signed [31:0] lc12_r, rc12_r, fc12_r, bc12_r;
  logic               last12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc_r   <= pt.pos_x * cos_q16;
      p_ys_r   <= pt.pos_y * sin_q16;
      p_xs_r   <= pt.pos_x * sin_q16;
      p_yc_r   <= pt.pos_y * cos_q16;
      p_lf_r   <= $signed({1'b0, lf_r}) * pt.heading;
      p_lr_r   <= $signed({1'b0, lr_r}) * pt.heading;
      p_w_r    <= $signed({1'b0, width_r}) * pt.heading;
      s12_r    <= sin_q16;
      c12_r    <= cos_q16;
      lc12_r   <= pt.left_clear;
      rc12_r   <= pt.right_clear;
      fc12_r   <= pt.front_clear;
      bc12_r   <= pt.back_clear;
      last12_r <= pt.last_point;
    end
  end

  // stage 13: rounded projections and heading terms
  logic v13_r;
  logic signed [50:0] side_l, side_r_d, fsum, bsum;
  logic signed [50:0] rl, rr, rf, rb;
  logic signed [63:0] lfphi_t, lrphi_t, wphi_t;
  logic signed [35:0] ld_r, rd_r, fd_r, bd_r;
  logic signed [47:0] lfphi_r, lrphi_r;
  logic signed [46:0] wphi_r;
  logic signed [17:0] s13_r, c13_r;
  logic               last13_r;

  always_comb begin
    side_l   = 51'(p_yc_r) - 51'(p_xs_r);
    side_r_d = 51'(p_xs_r) - 51'(p_yc_r);
    fsum     = 51'(p_xc_r) + 51'(p_ys_r);
    bsum     = 51'sd0 - fsum;
    rl       = (side_l + 51'sd32768) >>> 16;
    rr       = (side_r_d + 51'sd32768) >>> 16;
    rf       = (fsum + 51'sd32768) >>> 16;
    rb       = (bsum + 51'sd32768) >>> 16;
    lfphi_t  = (p_lf_r + 64'sd32768) >>> 16;
    lrphi_t  = (p_lr_r + 64'sd32768) >>> 16;
    wphi_t   = (p_w_r + 64'sd65536) >>> 17;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_r     <= 36'(rl) + 36'(lc12_r);
      rd_r     <= 36'(rr) + 36'(rc12_r);
      fd_r     <= 36'(rf) + 36'(fc12_r);
      bd_r     <= 36'(rb) + 36'(bc12_r);
      lfphi_r  <= lfphi_t[47:0];
      lrphi_r  <= lrphi_t[47:0];
      wphi_r   <= wphi_t[46:0];
      s13_r    <= s12_r;
      c13_r    <= c12_r;
      last13_r <= last12_r;
    end
  end

  // stage 14: constant terms, saturated
  logic signed [32:0] ns, nf;
  logic signed [49:0] d_full [8];
  logic signed [31:0] d14_r [8];
  logic signed [17:0] s14_r, c14_r;
  logic               last14_r;

  always_comb begin
    ns = -$signed({2'b0, slack_r}) - $signed({2'b0, side_r});
    nf = -$signed({2'b0, slack_r}) - $signed({2'b0, face_r});
    d_full[0] = 50'(ns) + 50'(ld_r) + 50'(lfphi_r);
    d_full[1] = 50'(ns) + 50'(ld_r) - 50'(lrphi_r);
    d_full[2] = 50'(ns) + 50'(rd_r) - 50'(lfphi_r);
    d_full[3] = 50'(ns) + 50'(rd_r) + 50'(lrphi_r);
    d_full[4] = 50'(nf) + 50'(fd_r) - 50'($signed({1'b0, lf_r})) - 50'(wphi_r);
    d_full[5] = 50'(nf) + 50'(fd_r) - 50'($signed({1'b0, lf_r})) + 50'(wphi_r);
    d_full[6] = 50'(nf) + 50'(bd_r) - 50'($signed({1'b0, lr_r})) - 50'(wphi_r);
    d_full[7] = 50'(nf) + 50'(bd_r) - 50'($signed({1'b0, lr_r})) + 50'(wphi_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) d14_r[i] <= sat32(d_full[i]);
      s14_r    <= s13_r;
      c14_r    <= c13_r;
      last14_r <= last13_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
    end else if (en) begin
      v12_r <= dv_r[SC_LAT-1];
      v13_r <= v12_r;
      v14_r <= v13_r;
    end
  end

  // row serialiser: holds one finished point and walks its eight rows
  logic signed [31:0] ser_d_r [8];
  logic signed [17:0] ser_s_r, ser_c_r;
  logic               ser_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) ser_d_r[i] <= d14_r[i];
      ser_s_r    <= s14_r;
      ser_c_r    <= c14_r;
      ser_last_r <= last14_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      k_r     <= 3'd0;
    end else begin
      if (load) ser_v_r <= 1'b1;
      else if (out_acc && k_r == 3'd7) ser_v_r <= 1'b0;
      if (out_acc) k_r <= k_r + 3'd1;
    end
  end

  logic signed [31:0] hw;
  assign hw = $signed({1'b0, 31'((32'(width_r) + 32'd1) >> 1)});

  always_comb begin
    out_valid         = ser_v_r;
    out_row_kind      = k_r;
    out_constant_term = ser_d_r[k_r];
    out_slack_column  = k_r[2];
    out_last_of_point = (k_r == 3'd7);
    out_last_of_path  = (k_r == 3'd7) & ser_last_r;
    case (k_r)
      3'd0: begin
        out_normal_x = -ser_s_r; out_normal_y = ser_c_r;
        out_heading_coeff = $signed({1'b0, lf_r});
      end
      3'd1: begin
        out_normal_x = -ser_s_r; out_normal_y = ser_c_r;
        out_heading_coeff = -$signed({1'b0, lr_r});
      end
      3'd2: begin
        out_normal_x = ser_s_r; out_normal_y = -ser_c_r;
        out_heading_coeff = -$signed({1'b0, lf_r});
      end
      3'd3: begin
        out_normal_x = ser_s_r; out_normal_y = -ser_c_r;
        out_heading_coeff = $signed({1'b0, lr_r});
      end
      3'd4: begin
        out_normal_x = ser_c_r; out_normal_y = ser_s_r;
        out_heading_coeff = -hw;
      end
      3'd5: begin
        out_normal_x = ser_c_r; out_normal_y = ser_s_r;
        out_heading_coeff = hw;
      end
      3'd6: begin
        out_normal_x = -ser_c_r; out_normal_y = -ser_s_r;
        out_heading_coeff = -hw;
      end
      default: begin
        out_normal_x = -ser_c_r; out_normal_y = -ser_s_r;
        out_heading_coeff = hw;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/vchp_sincos.sv
`default_nettype none
module vchp_sincos
  import vchp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] heading,
  output logic signed [17:0]      sin_q16,
  output logic signed [17:0]      cos_q16
);

  logic signed [64:0] plo_r;
  logic        [31:0] phi_r;
  logic        [1:0]  q2_r, q3_r, q4_r, q5_r, q6_r, q7_r, q8_r, q9_r, q10_r;
  logic signed [29:0] r2_r;
  logic signed [31:0] t3_r, t4_r, t5_r, t6_r, t7_r, t8_r, t9_r;
  logic        [30:0] t2_4_r, t2_5_r, t2_6_r, t2_7_r, t2_8_r, t2_9_r;
  logic        [30:0] s5_r, c5_r, s6_r, c6_r, s7_r, c7_r, s8_r, c8_r, s9_r, c9_r, c10_r;
  logic signed [32:0] s10_r;

  logic        [31:0] ph;
  logic        [31:0] ph_off;
  logic signed [62:0] tprod;
  logic signed [63:0] tsq;
  logic signed [63:0] sprod;
  logic signed [32:0] cfin;
  logic signed [32:0] so, co;

  always_comb begin
    ph     = plo_r[63:32] + phi_r;
    ph_off = ph + 32'h2000_0000;
    tprod  = r2_r * $signed({1'b0, PI_Q30});
    tsq    = t3_r * t3_r;
    sprod  = t9_r * $signed({33'd0, s9_r});
    cfin   = ONE_Q30 - $signed({3'd0, c10_r[30:1]});
    case (q10_r)
      2'd0: begin so = s10_r; co = cfin; end
      2'd1: begin so = cfin; co = -s10_r; end
      2'd2: begin so = -s10_r; co = -cfin; end
      default: begin so = -cfin; co = s10_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // turn phase from two partial products
      plo_r  <= heading * $signed({1'b0, TURN_LO});
      phi_r  <= 32'(heading * $signed({18'd0, TURN_HI}));
      // nearest quadrant and remainder
      q2_r   <= ph_off[31:30];
      r2_r   <= {~ph_off[29], ph_off[28:0]};
      q3_r   <= q2_r;
      t3_r   <= tprod[62:31];
      q4_r   <= q3_r;
      t4_r   <= t3_r;
      t2_4_r <= tsq[60:30];
      // horner series, sine and cosine side by side
      q5_r   <= q4_r;
      t5_r   <= t4_r;
      t2_5_r <= t2_4_r;
      s5_r   <= 31'(ONE_Q30) - div_rcp(t2_4_r, RCP_42, SH_42);
      c5_r   <= 31'(ONE_Q30) - div_rcp(t2_4_r, RCP_56, SH_56);
      q6_r   <= q5_r;
      t6_r   <= t5_r;
      t2_6_r <= t2_5_r;
      s6_r   <= mul30u(t2_5_r, s5_r);
      c6_r   <= mul30u(t2_5_r, c5_r);
      q7_r   <= q6_r;
      t7_r   <= t6_r;
      t2_7_r <= t2_6_r;
      s7_r   <= 31'(ONE_Q30) - div_rcp(s6_r, RCP_20, SH_20);
      c7_r   <= 31'(ONE_Q30) - div_rcp(c6_r, RCP_30, SH_30);
      q8_r   <= q7_r;
      t8_r   <= t7_r;
      t2_8_r <= t2_7_r;
      s8_r   <= mul30u(t2_7_r, s7_r);
      c8_r   <= mul30u(t2_7_r, c7_r);
      q9_r   <= q8_r;
      t9_r   <= t8_r;
      t2_9_r <= t2_8_r;
      s9_r   <= 31'(ONE_Q30) - div_rcp(s8_r, RCP_6, SH_6);
      c9_r   <= 31'(ONE_Q30) - div_rcp(c8_r, RCP_12, SH_12);
      q10_r  <= q9_r;
      s10_r  <= sprod[62:30];
      c10_r  <= mul30u(t2_9_r, c9_r);
      // quadrant rotation and rounding to q16
      sin_q16 <= to_q16(so);
      cos_q16 <= to_q16(co);
    end
  end

endmodule
`default_nettype wire

>>> sv/vchp_checker.sv
`default_nettype none
module vchp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [2:0]         out_row_kind,
  input wire logic signed [31:0] out_constant_term,
  input wire logic               out_last_of_point,
  input wire logic               out_last_of_path
);

  // rows of one point follow each other without gaps
  a_row_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_row_kind != 3'd7
    |=> out_valid && out_row_kind == $past(out_row_kind) + 3'd1)
    else $error("row sequence broken");

  // a new point always starts at the first row
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_row_kind == 3'd7
    |=> !out_valid || out_row_kind == 3'd0)
    else $error("point does not start at first row");

  a_path_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_path |-> out_last_of_point && out_row_kind == 3'd7)
    else $error("path end off the last row");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall
    |=> out_valid && $stable(out_row_kind) && $stable(out_constant_term))
    else $error("stalled request changed");

endmodule

bind vehicle_collision_halfplane_coeffs vchp_checker u_vchp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_row_kind      (out_row_kind),
  .out_constant_term (out_constant_term),
  .out_last_of_point (out_last_of_point),
  .out_last_of_path  (out_last_of_path)
);
`default_nettype wire
